FILE: hdl/itgl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itgl_pkg
// Shared types, constants and codes for the interval table with gap listing.
// ----------------------------------------------------------------------------
package itgl_pkg;

  localparam int TableDepthDefault = 16;
  localparam int OffsetBitsDefault = 16;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_LIST   = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_ENTRY  = 2'd1,
    KIND_GAP    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OVERLAP = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_LOAD    = 3'd1,
    CMD_SCAN    = 3'd2,
    CMD_SHIFT   = 3'd3,
    CMD_WRITE   = 3'd4,
    CMD_EMIT    = 3'd5
  } cmd_op_t;

  typedef enum logic [2:0] {
    EM_STATUS   = 3'd0,
    EM_GAP      = 3'd1,
    EM_ENTRY    = 3'd2,
    EM_TAIL     = 3'd3,
    EM_NONE     = 3'd4
  } emit_sel_t;

  typedef struct packed {
    cmd_op_t   op;
    emit_sel_t sel;
    status_t   status;
    logic      last;
  } itgl_cmd_t;

  typedef struct packed {
    logic hit;
    logic full;
    logic empty;
    logic scan_done;
    logic shift_done;
    logic gap_needed;
    logic tail_needed;
    logic at_last;
  } itgl_stat_t;

endpackage
`default_nettype wire

FILE: hdl/itgl_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itgl_stream_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface itgl_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/itgl_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itgl_datapath
// Interval storage, scan/shift pointer and result formation.
// ----------------------------------------------------------------------------
module itgl_datapath
  import itgl_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDefault,
  parameter int OFFSET_BITS = OffsetBitsDefault
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire itgl_cmd_t              cmd,
  input  wire logic                   in_action,
  input  wire logic [OFFSET_BITS-1:0] in_first,
  input  wire logic [OFFSET_BITS-1:0] in_second,
  output itgl_stat_t                  stat,
  output logic                        is_list,
  output logic [1:0]                  res_kind,
  output logic [1:0]                  res_status,
  output logic [OFFSET_BITS-1:0]      res_begin,
  output logic [OFFSET_BITS:0]        res_end,
  output logic                        res_last
);
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [OFFSET_BITS-1:0] start_mem [TABLE_DEPTH];
  logic [OFFSET_BITS-1:0] end_mem [TABLE_DEPTH];
  logic [CW-1:0]          count;
  logic [CW-1:0]          ptr;
  logic [CW-1:0]          pos;
  logic [OFFSET_BITS-1:0] b;
  logic [OFFSET_BITS-1:0] e;
  logic [OFFSET_BITS-1:0] gap_from;
  logic                   hit;
  logic [OFFSET_BITS-1:0] s;
  logic [OFFSET_BITS-1:0] t;
  logic                   cur_hit;
  logic [IW-1:0]          idx;
  logic [IW-1:0]          idx_m1;

  assign idx    = ptr[IW-1:0];
  assign idx_m1 = IW'(ptr - CW'(1));
  assign s      = start_mem[idx];
  assign t      = end_mem[idx];
  assign cur_hit = (b >= s && b < t) || (e > s && e <= t) || (b <= s && e >= t);

  always_comb begin
    stat.hit         = hit;
    stat.full        = (count >= CW'(TABLE_DEPTH));
    stat.empty       = (count == '0);
    stat.scan_done   = (ptr >= count);
    stat.shift_done  = (ptr <= pos);
    stat.gap_needed  = (s > gap_from);
    stat.tail_needed = (ptr >= count) ? (gap_from <= e) : (t <= e);
    stat.at_last     = (ptr + CW'(1) >= count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.op == CMD_WRITE) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CMD_LOAD: begin
        b        <= in_first;
        e        <= in_second;
        is_list  <= in_action;
        gap_from <= in_first;
        hit      <= 1'b0;
        ptr      <= '0;
        pos      <= '0;
      end
      CMD_SCAN: begin
        if (cur_hit) hit <= 1'b1;
        if (s <= b) pos <= ptr + CW'(1);
        ptr <= ptr + CW'(1);
      end
      CMD_SHIFT: begin
        if (ptr > pos) begin
          start_mem[idx] <= start_mem[idx_m1];
          end_mem[idx]   <= end_mem[idx_m1];
          ptr            <= ptr - CW'(1);
        end
      end
      CMD_WRITE: begin
        start_mem[pos[IW-1:0]] <= b;
        end_mem[pos[IW-1:0]]   <= e;
      end
      CMD_EMIT: begin
        res_status <= cmd.status;
        res_last   <= cmd.last;
        unique case (cmd.sel)
          EM_GAP: begin
            res_kind  <= KIND_GAP;
            res_begin <= gap_from;
            res_end   <= {1'b0, s};
            gap_from  <= s;
          end
          EM_ENTRY: begin
            res_kind  <= KIND_ENTRY;
            res_begin <= s;
            res_end   <= {1'b0, t};
            gap_from  <= t;
            ptr       <= ptr + CW'(1);
          end
          EM_TAIL: begin
            res_kind  <= KIND_GAP;
            res_begin <= gap_from;
            res_end   <= {1'b0, e} + (OFFSET_BITS+1)'(1);
          end
          default: begin
            res_kind  <= KIND_STATUS;
            res_begin <= '0;
            res_end   <= '0;
          end
        endcase
      end
      default: begin
        if (cmd.op == CMD_NONE && ptr == '1) ptr <= ptr;
      end
    endcase
  end
endmodule
`default_nettype wire

FILE: hdl/itgl_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itgl_ctrl
// Sequencer for insert and list items and the output handshake.
// ----------------------------------------------------------------------------
module itgl_ctrl
  import itgl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire itgl_stat_t stat,
  input  wire logic       is_list,
  output itgl_cmd_t       cmd
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DEC   = 8'b0000_0010,
    S_SCAN  = 8'b0000_0100,
    S_SHIFT = 8'b0000_1000,
    S_WRITE = 8'b0001_0000,
    S_WALK  = 8'b0010_0000,
    S_ENTRY = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   busy;

  assign busy     = out_valid && !out_ready;
  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    state_next = state;
    cmd        = '{op: CMD_NONE, sel: EM_NONE, status: ST_OK, last: 1'b0};
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.op     = CMD_LOAD;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (is_list) begin
          if (stat.empty) begin
            cmd = '{op: CMD_EMIT, sel: EM_STATUS, status: ST_EMPTY, last: 1'b1};
            state_next = S_OUT;
          end else begin
            state_next = S_WALK;
          end
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          if (stat.hit) begin
            cmd = '{op: CMD_EMIT, sel: EM_STATUS, status: ST_OVERLAP, last: 1'b1};
            state_next = S_OUT;
          end else if (stat.full) begin
            cmd = '{op: CMD_EMIT, sel: EM_STATUS, status: ST_FULL, last: 1'b1};
            state_next = S_OUT;
          end else begin
            cmd.op     = CMD_SHIFT;
            state_next = S_SHIFT;
          end
        end else begin
          cmd.op = CMD_SCAN;
        end
      end
      S_SHIFT: begin
        if (stat.shift_done) begin
          cmd.op     = CMD_WRITE;
          state_next = S_WRITE;
        end else begin
          cmd.op = CMD_SHIFT;
        end
      end
      S_WRITE: begin
        cmd = '{op: CMD_EMIT, sel: EM_STATUS, status: ST_OK, last: 1'b1};
        state_next = S_OUT;
      end
      S_WALK: begin
        if (!busy) begin
          if (stat.scan_done) begin
            if (stat.tail_needed) begin
              cmd = '{op: CMD_EMIT, sel: EM_TAIL, status: ST_OK, last: 1'b1};
              state_next = S_OUT;
            end else begin
              state_next = S_IDLE;
            end
          end else if (stat.gap_needed) begin
            cmd = '{op: CMD_EMIT, sel: EM_GAP, status: ST_OK, last: 1'b0};
            state_next = S_ENTRY;
          end else begin
            cmd = '{op: CMD_EMIT, sel: EM_ENTRY, status: ST_OK,
                    last: stat.at_last && !stat.tail_needed};
            state_next = S_WALK;
          end
        end
      end
      S_ENTRY: begin
        if (!busy) begin
          cmd = '{op: CMD_EMIT, sel: EM_ENTRY, status: ST_OK,
                  last: stat.at_last && !stat.tail_needed};
          state_next = S_WALK;
        end
      end
      S_OUT: begin
        if (!busy) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == CMD_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

FILE: hdl/interval_table_with_gap_listing_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// interval_table_with_gap_listing_core
// Sorted table of half-open intervals; insert with overlap check, list with gaps.
// ----------------------------------------------------------------------------
// Insert: scan entries, shift those above the new slot, write it, then the result;
//   a rejected insert (overlap or full) answers as soon as the scan is done.
// List: decode, then one gap or entry per cycle while the output is not stalled.
// One item at a time; input accepted in the cycle after the last result is taken.
// Reset (rst, synchronous) empties the table; the stores keep old contents.
module interval_table_with_gap_listing_core
  import itgl_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDefault,
  parameter int OFFSET_BITS = OffsetBitsDefault
) (
  input wire logic clk,
  input wire logic rst,
  itgl_stream_if.sink   in_ch,
  itgl_stream_if.source out_ch
);
  itgl_cmd_t  cmd;
  itgl_stat_t stat;
  logic       is_list;

  itgl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .stat     (stat),
    .is_list  (is_list),
    .cmd      (cmd)
  );

  itgl_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_action (in_ch.data.action),
    .in_first  (in_ch.data.first_offset),
    .in_second (in_ch.data.second_offset),
    .stat      (stat),
    .is_list   (is_list),
    .res_kind  (out_ch.data.kind),
    .res_status(out_ch.data.status),
    .res_begin (out_ch.data.seg_begin),
    .res_end   (out_ch.data.seg_end),
    .res_last  (out_ch.data.last)
  );
endmodule
`default_nettype wire
